### src/rpn_pkg.sv
`default_nettype none

package rpn_pkg;

   // Width of every stack entry and of the result value (signed fixed point).
   localparam int ValueWidth = 48;

   typedef logic signed [ValueWidth-1:0] value_type;

   localparam value_type ValueMax = 48'sh7FFF_FFFF_FFFF;
   localparam value_type ValueMin = 48'sh8000_0000_0000;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_END  = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_TOO_BIG  = 3'd1,
      ST_MISSING  = 3'd2,
      ST_DIVZERO  = 3'd3,
      ST_COUNT    = 3'd4,
      ST_OVERFLOW = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2,
      ALU_DIV = 2'd3
   } alu_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_LEFT,
      S_ALU_START,
      S_ALU_WAIT,
      S_RD_END,
      S_OUT
   } seq_state_type;

   typedef enum logic [1:0] {
      A_IDLE,
      A_RUN,
      A_FIN,
      A_DONE
   } alu_state_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic      done;
      value_type result;
   } alu_rsp_type;

endpackage

`default_nettype wire

### src/rpn_alu.sv
`default_nettype none

// Shared arithmetic unit. One adder serves all four operations: add and
// subtract finish in one step, multiply runs one shift-add step per
// multiplier bit, and divide runs one restoring step per quotient bit.
module rpn_alu
   import rpn_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type req,
   input  value_type   left,
   input  value_type   right,
   output alu_rsp_type rsp
);

   localparam int LoWidth   = ValueWidth + FRAC_BITS;
   localparam int CntWidth  = $clog2(LoWidth);
   localparam int ProdWidth = 2 * ValueWidth;
   localparam int AddWidth  = ValueWidth + 2;
   localparam logic [ProdWidth-1:0] MagPosMax = ProdWidth'(ValueMax);
   localparam logic [ProdWidth-1:0] MagNegMax = ProdWidth'(1) << (ValueWidth - 1);

   alu_state_type state_ff, state_in;

   alu_op_type                op_ff;
   logic                      neg_ff;
   value_type                 a_ff;
   value_type                 b_ff;
   logic [ValueWidth-1:0]     opd_ff;
   logic [ValueWidth:0]       hi_ff;
   logic [LoWidth-1:0]        lo_ff;
   logic [CntWidth-1:0]       cnt_ff;
   value_type                 result_ff;

   logic [AddWidth-1:0]       add_x;
   logic [AddWidth-1:0]       add_y;
   logic                      add_cin;
   logic [AddWidth-1:0]       add_sum;
   logic [ValueWidth:0]       rem_sh;
   logic [ValueWidth:0]       mul_acc;
   value_type                 addsub_sat;
   logic [ProdWidth-1:0]      prod;
   logic [ProdWidth-1:0]      mag_fin;
   value_type                 fin_sat;
   logic                      last_step;

   function automatic logic [ValueWidth-1:0] mag_of(input value_type v);
      mag_of = v[ValueWidth-1] ? ValueWidth'(-v) : ValueWidth'(v);
   endfunction

   assign rem_sh = {hi_ff[ValueWidth-1:0], lo_ff[LoWidth-1]};

   // Operand selection for the single shared adder.
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_cin = 1'b0;
      case (op_ff)
         ALU_ADD: begin
            add_x = AddWidth'(a_ff);
            add_y = AddWidth'(b_ff);
         end
         ALU_SUB: begin
            add_x   = AddWidth'(a_ff);
            add_y   = ~AddWidth'(b_ff);
            add_cin = 1'b1;
         end
         ALU_MUL: begin
            add_x = AddWidth'(hi_ff[ValueWidth-1:0]);
            add_y = AddWidth'(opd_ff);
         end
         default: begin
            add_x   = AddWidth'(rem_sh);
            add_y   = ~AddWidth'(opd_ff);
            add_cin = 1'b1;
         end
      endcase
      add_sum = add_x + add_y + AddWidth'(add_cin);
   end

   // Saturation of the add and subtract result.
   always_comb begin
      if (add_sum[AddWidth-1:ValueWidth-1] == '0 || add_sum[AddWidth-1:ValueWidth-1] == '1) begin
         addsub_sat = value_type'(add_sum[ValueWidth-1:0]);
      end else if (add_sum[AddWidth-1]) begin
         addsub_sat = ValueMin;
      end else begin
         addsub_sat = ValueMax;
      end
   end

   assign mul_acc = lo_ff[0] ? add_sum[ValueWidth:0] : {1'b0, hi_ff[ValueWidth-1:0]};

   // Product sits in hi and in the upper part of lo once all steps are done.
   assign prod = {hi_ff[ValueWidth-1:0], lo_ff[LoWidth-1:FRAC_BITS]};

   always_comb begin
      if (op_ff == ALU_MUL) begin
         mag_fin = prod >> FRAC_BITS;
      end else begin
         mag_fin = ProdWidth'(lo_ff);
      end
      if (neg_ff) begin
         fin_sat = (mag_fin > MagNegMax) ? ValueMin : value_type'(-mag_fin[ValueWidth-1:0]);
      end else begin
         fin_sat = (mag_fin > MagPosMax) ? ValueMax : value_type'(mag_fin[ValueWidth-1:0]);
      end
   end

   assign last_step = (op_ff == ALU_MUL) ? (cnt_ff == CntWidth'(ValueWidth - 1))
                                         : (cnt_ff == CntWidth'(LoWidth - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (req.start) begin
               state_in = A_RUN;
            end
         end
         A_RUN: begin
            if (op_ff == ALU_ADD || op_ff == ALU_SUB) begin
               state_in = A_DONE;
            end else if (last_step) begin
               state_in = A_FIN;
            end
         end
         A_FIN: begin
            state_in = A_DONE;
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         A_IDLE: begin
            if (req.start) begin
               op_ff  <= req.op;
               a_ff   <= left;
               b_ff   <= right;
               neg_ff <= left[ValueWidth-1] ^ right[ValueWidth-1];
               opd_ff <= (req.op == ALU_MUL) ? mag_of(left) : mag_of(right);
               hi_ff  <= '0;
               cnt_ff <= '0;
               if (req.op == ALU_MUL) begin
                  lo_ff <= LoWidth'(mag_of(right));
               end else begin
                  lo_ff <= LoWidth'(mag_of(left)) << FRAC_BITS;
               end
            end
         end
         A_RUN: begin
            cnt_ff <= cnt_ff + CntWidth'(1);
            case (op_ff) inside
               ALU_ADD, ALU_SUB: begin
                  result_ff <= addsub_sat;
               end
               ALU_MUL: begin
                  hi_ff <= (ValueWidth + 1)'(mul_acc[ValueWidth:1]);
                  lo_ff <= {mul_acc[0], lo_ff[LoWidth-1:1]};
               end
               default: begin
                  if (!add_sum[AddWidth-1]) begin
                     hi_ff <= add_sum[ValueWidth:0];
                  end else begin
                     hi_ff <= rem_sh;
                  end
                  lo_ff <= {lo_ff[LoWidth-2:0], ~add_sum[AddWidth-1]};
               end
            endcase
         end
         A_FIN: begin
            result_ff <= fin_sat;
         end
         default: begin
         end
      endcase
   end

   assign rsp.done   = (state_ff == A_DONE);
   assign rsp.result = result_ff;

endmodule

`default_nettype wire

### src/rpn_stack_evaluator.sv
`default_nettype none

// Reverse Polish notation evaluator for signed fixed-point values with
// FRAC_BITS fraction bits in 48 bits. Each item on the req_ channel is one
// token: push a value, add, subtract, multiply, divide, or end of expression.
// Every accepted item produces exactly one result item on the rsp_ channel:
// the current error status, and on the end token also done_res and the value.
// An item is accepted when req_valid is high and req_stall is low; the block
// holds req_stall high while it works on an item, one item at a time.
// Push, unused and ignored tokens go from acceptance straight to the output
// state; an end token that returns a value first reads the bottom entry, one
// that reports an error does not. Operators read both operands, and a divide
// by zero is then reported without starting the ALU. Add and subtract take one
// ALU step, multiply one shift-add step per multiplier bit and divide one
// restoring step per quotient bit, all on one shared adder in rpn_alu. The next
// item is accepted at the edge where the previous result may first be taken.
// The result sits in an output register; while rsp_stall holds it, the next
// item is still accepted and worked on, and only its hand-off waits.
// Reset (synchronous, active high) empties the stack, clears the error and
// drops rsp_valid. The stack storage itself is not cleared: entries are only
// read after they have been pushed.
module rpn_stack_evaluator
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = 32,
   parameter int FRAC_BITS   = 16
)
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_opcode,
   input  logic signed [47:0]      req_push_value,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_status,
   output logic signed [47:0]      rsp_final_value,
   output logic                    rsp_done_res
);

   localparam int AddrWidth  = $clog2(STACK_DEPTH);
   localparam int CountWidth = $clog2(STACK_DEPTH + 1);
   // Largest push allowed is just below ten.
   localparam value_type TenLimit = value_type'(48'sd10 <<< FRAC_BITS);

   seq_state_type state_ff, state_in;

   logic [CountWidth-1:0] count_ff, count_in;
   status_type            err_ff, err_in;
   alu_op_type            op_ff, op_in;
   value_type             right_ff;
   value_type             rdata_ff;
   status_type            pend_status_ff, pend_status_in;
   logic                  pend_done_ff, pend_done_in;
   value_type             pend_value_ff;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   value_type             rsp_value_ff;
   logic                  rsp_done_ff;

   // Operand stack; one write and one registered read per cycle.
   value_type             stack_mem [STACK_DEPTH];
   logic                  mem_we;
   logic [AddrWidth-1:0]  mem_waddr;
   value_type             mem_wdata;
   logic                  mem_re;
   logic [AddrWidth-1:0]  mem_raddr;

   logic [CountWidth-1:0] count_m1;
   logic [CountWidth-1:0] count_m2;
   logic                  accept;
   logic                  out_free;
   logic                  rsp_load;
   status_type            end_status;

   alu_req_type           alu_req;
   alu_rsp_type           alu_rsp;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign count_m1  = count_ff - CountWidth'(1);
   assign count_m2  = count_ff - CountWidth'(2);

   // An end token with a clean error but not exactly one entry fails here.
   assign end_status = (err_ff == ST_OK && count_ff != CountWidth'(1)) ? ST_COUNT : err_ff;

   rpn_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .left  (rdata_ff),
      .right (right_ff),
      .rsp   (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         err_ff   <= err_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Sequencer: decodes the token, walks the stack reads, drives the ALU
   // and hands the finished result to the output register.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      err_in         = err_ff;
      op_in          = op_ff;
      pend_status_in = pend_status_ff;
      pend_done_in   = pend_done_ff;
      mem_we         = 1'b0;
      mem_waddr      = count_ff[AddrWidth-1:0];
      mem_wdata      = req_push_value;
      mem_re         = 1'b0;
      mem_raddr      = count_m1[AddrWidth-1:0];
      alu_req.start  = 1'b0;
      alu_req.op     = op_ff;
      rsp_load       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_done_in = 1'b0;
               state_in     = S_OUT;
               unique case (req_opcode) inside
                  OP_PUSH: begin
                     if (err_ff == ST_OK) begin
                        if (req_push_value >= TenLimit) begin
                           err_in = ST_TOO_BIG;
                        end else if (count_ff == CountWidth'(STACK_DEPTH)) begin
                           err_in = ST_OVERFLOW;
                        end else begin
                           mem_we   = 1'b1;
                           count_in = count_ff + CountWidth'(1);
                        end
                     end
                  end
                  [OP_ADD:OP_DIV]: begin
                     if (err_ff == ST_OK) begin
                        if (count_ff < CountWidth'(2)) begin
                           err_in = ST_MISSING;
                        end else begin
                           mem_re   = 1'b1;
                           op_in    = alu_op_type'(2'(req_opcode - 3'(OP_ADD)));
                           state_in = S_RD_LEFT;
                        end
                     end
                  end
                  OP_END: begin
                     pend_done_in   = 1'b1;
                     pend_status_in = end_status;
                     count_in       = '0;
                     err_in         = ST_OK;
                     if (end_status == ST_OK) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        state_in  = S_RD_END;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD_LEFT: begin
            mem_re    = 1'b1;
            mem_raddr = count_m2[AddrWidth-1:0];
            state_in  = S_ALU_START;
         end
         S_ALU_START: begin
            if (op_ff == ALU_DIV && right_ff == '0) begin
               err_in   = ST_DIVZERO;
               state_in = S_OUT;
            end else begin
               alu_req.start = 1'b1;
               state_in      = S_ALU_WAIT;
            end
         end
         S_ALU_WAIT: begin
            if (alu_rsp.done) begin
               mem_we    = 1'b1;
               mem_waddr = count_m2[AddrWidth-1:0];
               mem_wdata = alu_rsp.result;
               count_in  = count_m1;
               state_in  = S_OUT;
            end
         end
         S_RD_END: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= stack_mem[mem_raddr];
      end
   end

   // Item payload registers; no reset needed.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      pend_status_ff <= pend_status_in;
      pend_done_ff   <= pend_done_in;
      if (state_ff == S_RD_LEFT) begin
         right_ff <= rdata_ff;
      end
      if (state_ff == S_RD_END) begin
         pend_value_ff <= rdata_ff;
      end
      if (rsp_load) begin
         rsp_status_ff <= pend_done_ff ? pend_status_ff : err_ff;
         rsp_value_ff  <= (pend_done_ff && pend_status_ff == ST_OK) ? pend_value_ff : '0;
         rsp_done_ff   <= pend_done_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_final_value = rsp_value_ff;
   assign rsp_done_res    = rsp_done_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(STACK_DEPTH))
      else $error("stack count exceeds the stack depth");

   a_alu_done_waited: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> state_ff == S_ALU_WAIT)
      else $error("ALU finished while the sequencer was not waiting for it");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_END) |=> (count_ff == '0 && err_ff == ST_OK))
      else $error("end token did not clear the stack and the error");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("block took no time to work on an accepted item");

   a_value_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |-> rsp_final_value == '0)
      else $error("non-final result carries a value");
`endif

endmodule

`default_nettype wire

### bench/rpn_eval_monitor.sv
`timescale 1ns / 100ps

// Watches both channels of the evaluator, keeps its own copy of the operand
// stack and the error state, and compares every result item with the answer
// predicted for the oldest token still waiting.
module rpn_eval_monitor
   import rpn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic signed [47:0] req_push_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [2:0]         rsp_status,
   input  logic signed [47:0] rsp_final_value,
   input  logic               rsp_done_res,
   output int                 mismatches,
   output int                 outstanding
);

   localparam int StackDepth = 32;
   localparam int FracBits   = 16;
   localparam value_type PushLimit = 48'sd10 <<< FracBits;

   typedef struct packed {
      status_type status;
      value_type  value;
      logic       done;
   } answer_type;

   value_type   stack_mem [StackDepth];
   int unsigned depth_now;
   status_type  sticky_err;
   answer_type  answers_due [$];

   function automatic logic [47:0] magnitude(input value_type v);
      return v[47] ? 48'(-v) : 48'(v);
   endfunction

   // Turns a sign and an unbounded magnitude into a saturated 48-bit value.
   function automatic value_type clamp_magnitude(input logic neg, input logic [127:0] mag);
      value_type t;
      t = mag[47:0];
      if (neg)
         return (mag > 128'h8000_0000_0000) ? ValueMin : -t;
      return (mag > 128'h7FFF_FFFF_FFFF) ? ValueMax : t;
   endfunction

   function automatic value_type sum_or_diff(input value_type l, input value_type r,
                                             input logic subtract);
      logic signed [48:0] s;
      s = subtract ? ({l[47], l} - {r[47], r}) : ({l[47], l} + {r[47], r});
      if (s[48] != s[47])
         return s[48] ? ValueMin : ValueMax;
      return s[47:0];
   endfunction

   function automatic value_type fixed_product(input value_type l, input value_type r);
      logic [127:0] p;
      p = {80'b0, magnitude(l)} * {80'b0, magnitude(r)};
      return clamp_magnitude(l[47] != r[47], p >> FracBits);
   endfunction

   function automatic value_type fixed_quotient(input value_type l, input value_type r);
      logic [127:0] num;
      num = {80'b0, magnitude(l)} << FracBits;
      return clamp_magnitude(l[47] != r[47], num / {80'b0, magnitude(r)});
   endfunction

   // Applies one token to the shadow stack and returns the answer it causes.
   function automatic answer_type evaluate_token(input logic [2:0] op, input value_type pv);
      answer_type a;
      value_type  lhs;
      value_type  rhs;
      a.status = ST_OK;
      a.value  = '0;
      a.done   = 1'b0;
      if (op == OP_END) begin
         a.done = 1'b1;
         if (sticky_err == ST_OK && depth_now != 1)
            sticky_err = ST_COUNT;
         a.status = sticky_err;
         if (sticky_err == ST_OK)
            a.value = stack_mem[0];
         depth_now  = 0;
         sticky_err = ST_OK;
      end else begin
         if (sticky_err == ST_OK) begin
            case (op) inside
               OP_PUSH: begin
                  if (pv >= PushLimit)
                     sticky_err = ST_TOO_BIG;
                  else if (depth_now >= StackDepth)
                     sticky_err = ST_OVERFLOW;
                  else begin
                     stack_mem[depth_now] = pv;
                     depth_now++;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (depth_now < 2)
                     sticky_err = ST_MISSING;
                  else begin
                     rhs = stack_mem[depth_now-1];
                     lhs = stack_mem[depth_now-2];
                     if (op == OP_DIV && rhs == 0)
                        sticky_err = ST_DIVZERO;
                     else begin
                        case (op)
                           OP_ADD:  lhs = sum_or_diff(lhs, rhs, 1'b0);
                           OP_SUB:  lhs = sum_or_diff(lhs, rhs, 1'b1);
                           OP_MUL:  lhs = fixed_product(lhs, rhs);
                           default: lhs = fixed_quotient(lhs, rhs);
                        endcase
                        depth_now--;
                        stack_mem[depth_now-1] = lhs;
                     end
                  end
               end
               default: ;
            endcase
         end
         a.status = sticky_err;
      end
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         foreach (stack_mem[i])
            stack_mem[i] = '0;
         depth_now  = 0;
         sticky_err = ST_OK;
         answers_due.delete();
         mismatches = 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("result item with no token waiting for it");
               mismatches++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_final_value !== want.value) begin
                  $error("final_value: expected %0d, got %0d", want.value, rsp_final_value);
                  mismatches++;
               end
               if (rsp_done_res !== want.done) begin
                  $error("done_res: expected %0d, got %0d", want.done, rsp_done_res);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            answers_due.push_back(evaluate_token(req_opcode, req_push_value));
         outstanding <= answers_due.size();
      end
   end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

// Top of the evaluator bench. It only makes stimulus and gives the verdict;
// prediction and comparison live in rpn_eval_monitor.
module testbench
   import rpn_pkg::*;
();

   // Opcodes that the block does not use. They must leave the state alone.
   localparam logic [2:0] OPC_SPARE_LO = 3'd6;
   localparam logic [2:0] OPC_SPARE_HI = 3'd7;

   localparam value_type PushLimit = 48'sd10 <<< 16;
   localparam value_type OneFixed  = 48'sd1 <<< 16;

   // The slowest token is a divide. With random gaps on both sides and two long
   // hold-offs a correct run stays well below this limit.
   localparam int CycleLimit = 1_200_000;
   localparam int TailCycles = 200;
   localparam int ItemTotal  = 1550;
   localparam int HoldCycles = 400;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_opcode = OP_END;
   value_type         req_push_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_status;
   value_type         rsp_final_value;
   logic              rsp_done_res;

   int                mismatches;
   int                outstanding;
   int                cycle_count = 0;
   int                tokens_sent = 0;
   int                idle_pct = 0;
   int                stall_pct = 0;
   logic              hold_kick = 1'b0;
   logic              hold_seen = 1'b0;
   int                hold_left = 0;

   always #4 clock = ~clock;

   rpn_stack_evaluator u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_final_value (rsp_final_value),
      .rsp_done_res    (rsp_done_res)
   );

   rpn_eval_monitor u_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_final_value (rsp_final_value),
      .rsp_done_res    (rsp_done_res),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   // Hard stop in case the block hangs on either channel.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side. Besides the random stall of the current phase, a toggle on
   // hold_kick starts a long hold-off that this process counts down itself,
   // so that the output register fills and the block stalls its input.
   always @(posedge clock) begin
      hold_seen <= hold_kick;
      if (hold_kick != hold_seen)
         hold_left <= HoldCycles;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
      rsp_stall <= (hold_kick != hold_seen) || (hold_left > 1) ||
                   (stall_pct != 0 && $urandom_range(99) < stall_pct);
   end

   // Small values, but also the full 48-bit range, the push limit and
   // its neighbors, and the extremes that drive the arithmetic into saturation.
   function automatic value_type pick_value();
      value_type v;
      case ($urandom_range(9))
         0: v = '0;
         1: v = (value_type'($urandom_range(19)) - 48'sd10) <<< 16;
         2, 3: v = value_type'($urandom_range(1310719)) - PushLimit;
         4: v = PushLimit + value_type'($urandom_range(3)) - 48'sd2;
         5: begin
            case ($urandom_range(7))
               0: v = ValueMin;
               1: v = ValueMax;
               2: v = -48'sd1;
               3: v = 48'sd1;
               4: v = PushLimit - 48'sd1;
               5: v = PushLimit;
               6: v = -OneFixed;
               default: v = OneFixed;
            endcase
         end
         6, 7: v = 48'({$urandom, $urandom});
         default: begin
            v = 48'({$urandom, $urandom});
            v[47] = 1'b1;
         end
      endcase
      return v;
   endfunction

   // Operand for a well-formed expression: values at or above the push limit
   // are mostly folded to negative ones so the expression gets evaluated.
   function automatic value_type pick_operand();
      value_type v;
      v = pick_value();
      if (v >= PushLimit && $urandom_range(19) != 0)
         v = -v;
      return v;
   endfunction

   function automatic logic [2:0] pick_operator();
      case ($urandom_range(3))
         0: return OP_ADD;
         1: return OP_SUB;
         2: return OP_MUL;
         default: return OP_DIV;
      endcase
   endfunction

   // Offers one item and returns at the edge that accepts it. Valid stays
   // high into the next item unless the sender decides to idle first. While
   // idle, the payload wanders so that it cannot be taken for a real item.
   task automatic send_token(input logic [2:0] op, input value_type v);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid      <= 1'b0;
         req_opcode     <= 3'($urandom_range(7));
         req_push_value <= 48'({$urandom, $urandom});
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_push_value <= v;
      do
         @(posedge clock);
      while (req_stall);
      tokens_sent++;
   endtask

   // Sender pauses until every predicted result item has been handed over.
   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
   endtask

   // One expression. A well-formed one pushes its operands and reduces the
   // stack to a single entry; now and then it is a deep one that pushes
   // everything first, which may run past the stack depth. A broken one is
   // random tokens of any opcode followed by the end marker.
   task automatic run_expression(input bit broken);
      int       n;
      int       pushed;
      int       depth;
      bit       deep;
      pushed = 0;
      depth  = 0;
      if (broken) begin
         n = $urandom_range(8, 1);
         repeat (n)
            send_token(3'($urandom_range(7)), pick_value());
      end else begin
         deep = ($urandom_range(24) == 0);
         n = deep ? $urandom_range(34, 30) : $urandom_range(6, 1);
         while (pushed < n || depth > 1) begin
            if (pushed < n && (deep || depth < 2 || $urandom_range(1) == 0)) begin
               send_token(OP_PUSH, pick_operand());
               pushed++;
               depth++;
            end else begin
               send_token(pick_operator(), pick_value());
               depth--;
            end
         end
      end
      send_token(OP_END, pick_value());
   endtask

   // Short directed opening: count error on an empty stack, the largest
   // value that may be pushed, the smallest one that may not, an operator
   // without operands, saturation of multiply and subtract, division by zero,
   // the two unused opcodes, and a divide that saturates negative.
   task automatic run_directed();
      send_token(OP_END, '0);
      send_token(OP_PUSH, PushLimit - 48'sd1);
      send_token(OP_END, '0);
      send_token(OP_PUSH, PushLimit);
      send_token(OP_PUSH, 48'sd1);
      send_token(OP_END, '0);
      send_token(OP_ADD, '0);
      send_token(OP_END, '0);
      send_token(OP_PUSH, ValueMin);
      send_token(OP_PUSH, -OneFixed);
      send_token(OP_MUL, '0);
      send_token(OP_PUSH, ValueMin);
      send_token(OP_SUB, '0);
      send_token(OP_PUSH, '0);
      send_token(OP_DIV, '0);
      send_token(OP_END, '0);
      send_token(OPC_SPARE_LO, ValueMax);
      send_token(OPC_SPARE_HI, ValueMin);
      send_token(OP_PUSH, ValueMin);
      send_token(OP_PUSH, 48'sd1);
      send_token(OP_DIV, '0);
      send_token(OP_PUSH, -48'sd1);
      send_token(OP_ADD, '0);
      send_token(OP_END, '0);
   endtask

   initial begin
      int  quota;
      bit  kicked;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Four phases of pacing: none, a sparse sender, a slow receiver, and
      // light random gaps on both sides. Each ends with a full drain, which
      // is also the point where the pacing may change safely.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 85; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 85; end
            default: begin idle_pct = 8; stall_pct = 8; end
         endcase
         if (phase == 0)
            run_directed();
         quota  = ItemTotal * (phase + 1) / 4;
         kicked = 1'b0;
         while (tokens_sent < quota) begin
            // Halfway through the phases with a busy sender, the receiver
            // holds off for a long stretch while items keep coming.
            if (!kicked && (phase == 0 || phase == 2) && tokens_sent > quota - ItemTotal / 8) begin
               hold_kick <= ~hold_kick;
               kicked = 1'b1;
            end
            run_expression($urandom_range(99) < 15);
         end
         drain_results();
      end

      // Let any stray result item show up before the verdict.
      repeat (TailCycles) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
src/rpn_pkg.sv
src/rpn_alu.sv
src/rpn_stack_evaluator.sv
bench/rpn_eval_monitor.sv
bench/testbench.sv
